### hdl/rdq_pkg.sv
package rdq_pkg;

    // width of the data words on the channels
    localparam int WORD_W = 64;

    // width of the entry count on the result channel
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_PEEK       = 3'd5
    } t_opcode;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic rd;
    } t_rdq_cmd;

endpackage

### hdl/rdq_ifs.sv
interface rdq_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                opcode;
    logic [rdq_pkg::WORD_W-1:0] data_in;

    modport source (output valid, output opcode, output data_in, input ready);
    modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface rdq_out_if;
    logic                      valid;
    logic                      ready;
    logic [rdq_pkg::WORD_W-1:0] front_word;
    logic [rdq_pkg::WORD_W-1:0] back_word;
    logic [rdq_pkg::CNT_W-1:0]  entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic [1:0]                status;

    modport source (
        output valid, output front_word, output back_word, output entry_count,
        output is_empty, output is_full, output status, input ready
    );
    modport sink (
        input valid, input front_word, input back_word, input entry_count,
        input is_empty, input is_full, input status, output ready
    );
endinterface

### hdl/rdq_ctrl.sv
module rdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rdq_pkg::t_rdq_cmd o_cmd
);

    rdq_pkg::t_state r_state;
    rdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rdq_pkg::S_EXEC;
                end
            end
            rdq_pkg::S_EXEC: n_state = rdq_pkg::S_READ;
            rdq_pkg::S_READ: n_state = rdq_pkg::S_RESP;
            rdq_pkg::S_RESP: begin
                if (i_out_ready) begin
                    n_state = rdq_pkg::S_IDLE;
                end
            end
            default: n_state = rdq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            rdq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rdq_pkg::S_EXEC: o_cmd.exec = 1'b1;
            rdq_pkg::S_READ: o_cmd.rd = 1'b1;
            rdq_pkg::S_RESP: o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

### hdl/rdq_dpath.sv
module rdq_dpath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rdq_pkg::t_rdq_cmd          i_cmd,
    input  logic [2:0]                 i_opcode,
    input  logic [rdq_pkg::WORD_W-1:0] i_data_in,
    output logic [rdq_pkg::WORD_W-1:0] o_front_word,
    output logic [rdq_pkg::WORD_W-1:0] o_back_word,
    output logic [CW-1:0]              o_entry_count,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic [1:0]                 o_status
);

    localparam int SW = AW + 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    rdq_pkg::t_opcode      r_op;
    logic [DATA_WIDTH-1:0] r_data;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rev;
    logic                  n_rev;
    rdq_pkg::t_status      r_status;
    rdq_pkg::t_status      n_status;
    logic [DATA_WIDTH-1:0] r_first;
    logic [DATA_WIDTH-1:0] r_last;

    logic          empty;
    logic          full;
    logic          at_front;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] end_sum;
    logic [AW-1:0] end_slot;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] last_slot;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(DEPTH));
    assign at_front = (r_op == rdq_pkg::OP_PUSH_FRONT) || (r_op == rdq_pkg::OP_POP_FRONT);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // slot just past the back of the ring
    assign end_sum  = {1'b0, r_head} + SW'(r_count);
    assign end_slot = (end_sum >= SW'(DEPTH)) ? AW'(end_sum - SW'(DEPTH)) : AW'(end_sum);

    // last occupied slot, only meaningful when not empty
    assign last_sum  = {1'b0, r_head} + SW'(r_count) - SW'(1);
    always_comb begin
        if (empty) begin
            last_slot = r_head;
        end else if (last_sum >= SW'(DEPTH)) begin
            last_slot = AW'(last_sum - SW'(DEPTH));
        end else begin
            last_slot = AW'(last_sum);
        end
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = rdq_pkg::STAT_OK;
        wr_en    = 1'b0;
        wr_addr  = end_slot;
        unique case (r_op)
            rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = rdq_pkg::STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    if (at_front != r_rev) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                    end
                end
            end
            rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = rdq_pkg::STAT_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    if (at_front != r_rev) begin
                        n_head = head_inc;
                    end
                end
            end
            rdq_pkg::OP_REVERSE: begin
                if (empty) begin
                    n_status = rdq_pkg::STAT_EMPTY;
                end else begin
                    n_rev = ~r_rev;
                end
            end
            default: n_status = rdq_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= rdq_pkg::t_opcode'(i_opcode);
            r_data <= i_data_in[DATA_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_first <= mem[r_head];
            r_last  <= mem[last_slot];
        end
    end

    always_comb begin
        o_front_word = '0;
        o_back_word  = '0;
        if (!empty) begin
            o_front_word = rdq_pkg::WORD_W'(r_rev ? r_last : r_first);
            o_back_word  = rdq_pkg::WORD_W'(r_rev ? r_first : r_last);
        end
    end

    assign o_entry_count = r_count;
    assign o_is_empty    = empty;
    assign o_is_full     = full;
    assign o_status      = r_status;

endmodule

### hdl/reversible_deque_unit.sv
// channel  | modport | payload                                         | accepted when
// i_cmd    | sink    | opcode, data_in                                 | valid && ready
// o_rsp    | source  | front_word, back_word, entry_count, is_empty,   | valid && ready
//          |         | is_full, status                                 |
//
// one word in, one word out, handled in these steps:
// capture, update ring and write store, read both ends, present result
// the result sits in registers until taken; no new word is taken meanwhile
// synchronous active-low reset clears head, count, reverse flag and controller
// the entry store has no reset; only words from occupied slots reach the outputs
module reversible_deque_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdq_in_if.sink    i_cmd,
    rdq_out_if.source o_rsp
);

    // ring index width and count width (count runs up to DEPTH)
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rdq_pkg::t_rdq_cmd cmd;
    logic [CW-1:0]     entry_count;

    // sequencer: idle, execute, read, respond
    rdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // ring pointers, entry store and result registers
    rdq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_cmd.opcode),
        .i_data_in     (i_cmd.data_in),
        .o_front_word  (o_rsp.front_word),
        .o_back_word   (o_rsp.back_word),
        .o_entry_count (entry_count),
        .o_is_empty    (o_rsp.is_empty),
        .o_is_full     (o_rsp.is_full),
        .o_status      (o_rsp.status)
    );

    // count width follows DEPTH; the channel carries a fixed-width count
    assign o_rsp.entry_count = rdq_pkg::CNT_W'(entry_count);

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 64;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = rdq_pkg::CNT_W;
    localparam int WORD_W         = rdq_pkg::WORD_W;
    localparam int WORD_COUNT     = 650;
    localparam int CALM_TAIL      = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 250;
    localparam int DRAIN_CYCLES   = 8;

    // opcodes 6 and 7 have no function and behave as a peek
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] back_word;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
        rdq_pkg::t_status  status;
    } t_deque_result;

    // mirror of the ring: head, count and reverse flag, plus the stored words
    class deque_scoreboard;
        logic [WORD_W-1:0] slots [DEPTH];
        logic [IDX_W-1:0]  head;
        logic [CNT_W-1:0]  count;
        logic              flipped;
        t_deque_result     awaited_results [$];
        int                mismatches;

        function new();
            head       = '0;
            count      = '0;
            flipped    = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function int held();
            return int'(count);
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("tb: mismatch %s got %h expected %h", what, got, want);
            mismatches++;
        endtask

        // apply one accepted word to the mirror and queue the result it gives
        function void note_command(logic [2:0] op, logic [WORD_W-1:0] data);
            t_deque_result     r;
            rdq_pkg::t_status  st;
            logic              at_front;
            logic [IDX_W-1:0]  slot;
            logic [WORD_W-1:0] first_word;
            logic [WORD_W-1:0] last_word;
            st       = rdq_pkg::STAT_OK;
            at_front = (op == rdq_pkg::OP_PUSH_FRONT) || (op == rdq_pkg::OP_POP_FRONT);
            case (op)
                rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
                    if (count == CNT_W'(DEPTH)) begin
                        st = rdq_pkg::STAT_FULL;
                    end else if (at_front != flipped) begin
                        head        = head - IDX_W'(1);
                        slots[head] = data;
                        count++;
                    end else begin
                        slot        = head + count[IDX_W-1:0];
                        slots[slot] = data;
                        count++;
                    end
                end
                rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
                    if (count == '0) begin
                        st = rdq_pkg::STAT_EMPTY;
                    end else if (at_front != flipped) begin
                        head = head + IDX_W'(1);
                        count--;
                    end else begin
                        count--;
                    end
                end
                rdq_pkg::OP_REVERSE: begin
                    if (count == '0) st = rdq_pkg::STAT_EMPTY;
                    else flipped = !flipped;
                end
                default: ;
            endcase
            first_word = '0;
            last_word  = '0;
            if (count != '0) begin
                slot       = head + count[IDX_W-1:0] - IDX_W'(1);
                first_word = slots[head];
                last_word  = slots[slot];
            end
            r.front_word  = flipped ? last_word : first_word;
            r.back_word   = flipped ? first_word : last_word;
            r.entry_count = count;
            r.is_empty    = (count == '0);
            r.is_full     = (count == CNT_W'(DEPTH));
            r.status      = st;
            awaited_results.push_back(r);
        endfunction

        task check_response(t_deque_result got);
            t_deque_result want;
            if (awaited_results.size() == 0) begin
                report("response with nothing awaited", got.front_word, '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.front_word !== want.front_word)
                    report("front_word", got.front_word, want.front_word);
                if (got.back_word !== want.back_word)
                    report("back_word", got.back_word, want.back_word);
                if (got.entry_count !== want.entry_count)
                    report("entry_count", WORD_W'(got.entry_count),
                           WORD_W'(want.entry_count));
                if (got.is_empty !== want.is_empty)
                    report("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
                if (got.is_full !== want.is_full)
                    report("is_full", WORD_W'(got.is_full), WORD_W'(want.is_full));
                if (got.status !== want.status)
                    report("status", WORD_W'(got.status), WORD_W'(want.status));
            end
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rdq_in_if  cmd_if ();
    rdq_out_if rsp_if ();

    reversible_deque_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    deque_scoreboard sb = new();

    int words_sent   = 0;
    int quiet_cycles = 0;
    int hold_cycles  = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // response monitor
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response('{rsp_if.front_word, rsp_if.back_word, rsp_if.entry_count,
                                rsp_if.is_empty, rsp_if.is_full, rsp_if.status});
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold when asked
    initial begin : receiver
        int   stall_left;
        logic next_ready;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                next_ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                next_ready = 1'b0;
                stall_left--;
            end else begin
                next_ready = 1'b1;
                if (rx_idle_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 17);
            end
            rsp_if.ready <= next_ready;
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // hold the word until the block takes it, then record it
    task automatic send_command(logic [2:0] op, logic [WORD_W-1:0] data);
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.opcode  <= op;
        cmd_if.data_in <= data;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sb.note_command(op, data);
        words_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 17));
    endtask

    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
        end
    endtask

    function automatic logic [2:0] any_push();
        return $urandom_range(0, 1) ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_BACK;
    endfunction

    function automatic logic [2:0] any_pop();
        return $urandom_range(0, 1) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_POP_BACK;
    endfunction

    function automatic logic [2:0] any_other();
        unique case ($urandom_range(0, 3))
            0:       return rdq_pkg::OP_REVERSE;
            1:       return rdq_pkg::OP_PEEK;
            2:       return OP_SPARE_A;
            default: return OP_SPARE_B;
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int extra;
        cmd_if.valid   = 1'b0;
        cmd_if.opcode  = rdq_pkg::OP_PEEK;
        cmd_if.data_in = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty queue cases, both ends, reverse flips, unused opcodes
        send_command(rdq_pkg::OP_PEEK,       random_word());
        send_command(rdq_pkg::OP_POP_FRONT,  random_word());
        send_command(rdq_pkg::OP_POP_BACK,   random_word());
        send_command(rdq_pkg::OP_REVERSE,    random_word());
        send_command(rdq_pkg::OP_PUSH_FRONT, '0);
        send_command(rdq_pkg::OP_PUSH_BACK,  '1);
        send_command(rdq_pkg::OP_PEEK,       random_word());
        send_command(rdq_pkg::OP_REVERSE,    random_word());
        send_command(rdq_pkg::OP_POP_FRONT,  random_word());
        send_command(rdq_pkg::OP_PUSH_FRONT, {32{2'b10}});
        send_command(rdq_pkg::OP_PUSH_BACK,  {32{2'b01}});
        send_command(OP_SPARE_A,             random_word());
        send_command(OP_SPARE_B,             random_word());
        send_command(rdq_pkg::OP_REVERSE,    random_word());
        send_command(rdq_pkg::OP_POP_BACK,   random_word());
        send_command(rdq_pkg::OP_POP_FRONT,  random_word());
        send_command(rdq_pkg::OP_POP_FRONT,  random_word());
        send_command(rdq_pkg::OP_POP_BACK,   random_word());

        phase = 0;
        while (words_sent < WORD_COUNT) begin
            if (words_sent >= WORD_COUNT - CALM_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            // block stalls behind a long receiver hold
            if (phase == 2) hold_cycles = LONG_HOLD;
            // let everything drain before going on
            if (phase == 4) begin
                @(negedge clk);
                cmd_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            unique case (phase % 3)
                0: begin
                    // fill to full, then push into a full queue
                    while (sb.held() < DEPTH) begin
                        if ($urandom_range(0, 9) == 0) send_command(any_other(), random_word());
                        else send_command(any_push(), random_word());
                    end
                    extra = $urandom_range(2, 5);
                    repeat (extra) begin
                        if ($urandom_range(0, 3) == 0) send_command(any_other(), random_word());
                        else send_command(any_push(), random_word());
                    end
                end
                1: begin
                    // drain to empty, then pop and reverse an empty queue
                    while (sb.held() > 0) begin
                        if ($urandom_range(0, 6) == 0) send_command(any_other(), random_word());
                        else send_command(any_pop(), random_word());
                    end
                    extra = $urandom_range(2, 5);
                    repeat (extra) begin
                        if ($urandom_range(0, 2) == 0)
                            send_command(rdq_pkg::OP_REVERSE, random_word());
                        else
                            send_command(any_pop(), random_word());
                    end
                end
                default: begin
                    repeat (60) send_command(3'($urandom_range(0, 7)), random_word());
                end
            endcase
            phase++;
        end

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/rdq_pkg.sv
hdl/rdq_ifs.sv
hdl/rdq_ctrl.sv
hdl/rdq_dpath.sv
hdl/reversible_deque_unit.sv
bench/tb.sv
